>>> hdl/gol_pkg.sv
// Shared parity matrix, syndrome helpers and types for the Golay (24,12) codec.
package gol_pkg;

  localparam int unsigned DataW = 12;
  localparam int unsigned WordW = 24;

  typedef logic [DataW-1:0] gol_data_t;
  typedef logic [WordW-1:0] gol_word_t;
  typedef logic [3:0]       gol_weight_t;

  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  localparam gol_data_t ROWS [DataW] = '{
    12'b110111000101,
    12'b101110001011,
    12'b011100010111,
    12'b111000101101,
    12'b110001011011,
    12'b100010110111,
    12'b000101101111,
    12'b001011011101,
    12'b010110111001,
    12'b101101110001,
    12'b011011100011,
    12'b111111111110
  };

  typedef struct packed {
    logic      command;
    gol_data_t payload;
    gol_word_t received_word;
  } gol_item_t;

  typedef struct packed {
    gol_data_t parity;
    gol_data_t data;
    gol_data_t syn;
    gol_data_t psyn;
  } gol_syn_t;

  typedef struct packed {
    gol_word_t code_word;
    gol_data_t data_out;
    logic [1:0] errors_fixed;
    logic       uncorrectable;
  } gol_result_t;

  function automatic gol_data_t parity_of(gol_data_t bits);
    gol_data_t acc;
    acc = '0;
    for (int k = 0; k < DataW; k++) begin
      if (bits[k]) begin
        acc = acc ^ ROWS[DataW-1-k];
      end
    end
    return acc;
  endfunction

  function automatic gol_weight_t weight12(gol_data_t v);
    gol_weight_t lo;
    gol_weight_t hi;
    lo = '0;
    hi = '0;
    for (int k = 0; k < DataW/2; k++) begin
      lo = lo + gol_weight_t'(v[k]);
      hi = hi + gol_weight_t'(v[k+DataW/2]);
    end
    return lo + hi;
  endfunction

endpackage

>>> hdl/gol_syndrome.sv
// Parity products of the registered word: encode parity and both decode syndromes.
module gol_syndrome import gol_pkg::*; (
  input  gol_item_t item,
  output gol_syn_t  syn
);

  gol_data_t rx_data;
  gol_data_t rx_parity;

  assign rx_data   = item.received_word[DataW-1:0];
  assign rx_parity = item.received_word[WordW-1:DataW];

  assign syn.parity = parity_of(item.payload);
  assign syn.data   = rx_data;
  assign syn.syn    = parity_of(rx_data) ^ rx_parity;
  assign syn.psyn   = parity_of(rx_parity) ^ rx_data;

endmodule

>>> hdl/gol_correct.sv
// Correction pattern search and result formatting for encode and decode.
module gol_correct import gol_pkg::*; (
  input  logic        command,
  input  gol_data_t   payload,
  input  gol_syn_t    syn,
  output gol_result_t result
);

  gol_weight_t w_syn;
  gol_weight_t w_psyn;
  gol_weight_t w_drow [DataW];
  gol_weight_t w_prow [DataW];
  gol_data_t   t_prow [DataW];

  always_comb begin
    w_syn  = weight12(syn.syn);
    w_psyn = weight12(syn.psyn);
    for (int i = 0; i < DataW; i++) begin
      w_drow[i] = weight12(syn.syn ^ ROWS[i]);
      t_prow[i] = syn.psyn ^ ROWS[i];
      w_prow[i] = weight12(t_prow[i]);
    end
  end

  always_comb begin
    gol_data_t  data;
    logic [1:0] errs;
    logic       found;
    data  = '0;
    errs  = '0;
    found = 1'b0;
    // Later assignments take priority, so the search runs in reverse order.
    for (int i = 0; i < DataW; i++) begin
      if (w_prow[i] <= 4'd2) begin
        data  = syn.data ^ t_prow[i];
        errs  = w_prow[i][1:0] + 2'd1;
        found = 1'b1;
      end
    end
    for (int i = 0; i < DataW; i++) begin
      if (w_drow[i] <= 4'd2) begin
        data  = syn.data ^ (gol_data_t'(1) << (DataW-1-i));
        errs  = w_drow[i][1:0] + 2'd1;
        found = 1'b1;
      end
    end
    if (w_psyn <= 4'd3) begin
      data  = syn.data ^ syn.psyn;
      errs  = w_psyn[1:0];
      found = 1'b1;
    end
    if (w_syn <= 4'd3) begin
      data  = syn.data;
      errs  = w_syn[1:0];
      found = 1'b1;
    end

    result = '0;
    if (command == CMD_ENCODE) begin
      result.code_word = {syn.parity, payload};
    end else if (found) begin
      result.data_out     = data;
      result.errors_fixed = errs;
    end else begin
      result.uncorrectable = 1'b1;
    end
  end

endmodule

>>> hdl/golay_24_12_codec.sv
// Top level of the extended Golay (24,12) encoder and decoder.
//
// One input channel (in_valid, in_stall) carries a word holding command,
// payload and received_word. Command encode turns payload into code_word;
// command decode corrects received_word and returns data_out, errors_fixed
// and uncorrectable. One output channel (out_valid, out_stall) carries one
// result word for every input word, in order.
// A word is taken into the input register, passes through the syndrome
// and correction logic and lands in the result register. One word is
// accepted per cycle while the output is not stalled. When the receiver
// stalls, the result register holds; the input register still takes a
// word if it is empty, and in_stall rises only when both registers are
// full and the output is stalled.
// Reset empties both registers; no other state is kept.
module golay_24_12_codec import gol_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [11:0] payload,
  input  logic [23:0] received_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] code_word,
  output logic [11:0] data_out,
  output logic [1:0]  errors_fixed,
  output logic        uncorrectable
);

  logic        s1_valid;
  gol_item_t   s1_item;
  gol_syn_t    s1_syn;
  gol_result_t s1_result;
  logic        s2_en;
  logic        s1_en;

  assign s2_en    = !out_valid || !out_stall;
  assign s1_en    = !s1_valid || s2_en;
  assign in_stall = !s1_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= in_valid;
    end
    if (s1_en && in_valid) begin
      s1_item <= '{command: command, payload: payload, received_word: received_word};
    end
  end

  gol_syndrome u_syndrome (
    .item (s1_item),
    .syn  (s1_syn)
  );

  gol_correct u_correct (
    .command (s1_item.command),
    .payload (s1_item.payload),
    .syn     (s1_syn),
    .result  (s1_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_en) begin
      out_valid <= s1_valid;
    end
    if (s2_en && s1_valid) begin
      code_word     <= s1_result.code_word;
      data_out      <= s1_result.data_out;
      errors_fixed  <= s1_result.errors_fixed;
      uncorrectable <= s1_result.uncorrectable;
    end
  end

`ifndef SYNTHESIS
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> s1_valid)
    else $error("Accepted word did not reach the input register.");

  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_en |=> s1_valid && $stable(s1_item))
    else $error("Waiting word left the input register.");

  a_bad_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && uncorrectable |-> data_out == '0 && errors_fixed == '0 && code_word == '0)
    else $error("Uncorrectable result carries data.");

  a_encode_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && code_word != '0 |-> !uncorrectable && data_out == '0)
    else $error("Encode result carries decode fields.");
`endif

endmodule
